/* rtl/wecost_pkg.sv */
// Shared constants, types and polynomial coefficients of the walking energy edge cost block.
package wecost_pkg;

    // Extra fraction bits carried by the square roots
    localparam int SQRT_EXTRA = 8;
    // Fraction bits of the gradient and of the polynomial accumulator
    localparam int GRAD_FRAC  = 16;
    // Quotient bits of the gradient divider (quotient stays below 128.0)
    localparam int GRAD_QBITS = 23;
    localparam int GRAD_W     = GRAD_QBITS + 1;
    localparam logic [GRAD_W-1:0] GRAD_LIMIT = GRAD_W'(24'd8388608);

    // Polynomial accumulator
    localparam int ACC_W = 64;
    localparam int MAG_W = ACC_W - 1;
    localparam int LO_W  = 32;
    localparam int HI_W  = MAG_W - LO_W;

    localparam int ID_W     = 32;
    localparam int COST_W   = 48;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_ZERO_RUN = 2'd1;
    localparam status_t ST_NONPOS   = 2'd2;

    // Leading coefficient, Q16
    localparam logic signed [ACC_W-1:0] POLY_C5 = 64'sd18382848;

    // Term added after each Horner product, Q16, signs folded in
    function automatic logic signed [ACC_W-1:0] horner_add(input logic [2:0] step);
        logic signed [ACC_W-1:0] c;
        case (step)
            3'd0:    c = -64'sd3846963;
            3'd1:    c = -64'sd5033165;
            3'd2:    c = 64'sd3401318;
            3'd3:    c = 64'sd1284506;
            3'd4:    c = 64'sd163840;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/wecost_root2.sv */
// Pipelined floor square root of two radicands, one result bit per stage.
module wecost_root2 #(
    parameter int RW = 42,
    parameter int SW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   rad_a,
    input  logic [2*RW-1:0]   rad_b,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [RW-1:0]     root_a,
    output logic [RW-1:0]     root_b,
    output logic [SW-1:0]     out_side
);
    localparam int REM_W = RW + 3;

    logic              v_reg     [0:RW-1];
    logic [SW-1:0]     side_reg  [0:RW-1];
    logic [2*RW-1:0]   rada_reg  [0:RW-1];
    logic [2*RW-1:0]   radb_reg  [0:RW-1];
    logic [REM_W-1:0]  rema_reg  [0:RW-1];
    logic [REM_W-1:0]  remb_reg  [0:RW-1];
    logic [RW-1:0]     roota_reg [0:RW-1];
    logic [RW-1:0]     rootb_reg [0:RW-1];

    // One digit: bring down a bit pair, try root*4+1
    function automatic logic [REM_W+RW-1:0] root_step(
        input logic [REM_W-1:0] rem,
        input logic [RW-1:0]    root,
        input logic [1:0]       pair
    );
        logic [REM_W-1:0] cat;
        logic [REM_W-1:0] trial;
        cat   = {rem[REM_W-3:0], pair};
        trial = REM_W'({root, 2'b01});
        if (cat >= trial) begin
            return {REM_W'(cat - trial), root[RW-2:0], 1'b1};
        end else begin
            return {cat, root[RW-2:0], 1'b0};
        end
    endfunction

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic              v_in;
        logic [SW-1:0]     side_in;
        logic [2*RW-1:0]   rada_in;
        logic [2*RW-1:0]   radb_in;
        logic [REM_W-1:0]  rema_in;
        logic [REM_W-1:0]  remb_in;
        logic [RW-1:0]     roota_in;
        logic [RW-1:0]     rootb_in;
        logic [REM_W+RW-1:0] a_next;
        logic [REM_W+RW-1:0] b_next;

        if (j == 0) begin : g_head
            assign v_in     = in_valid;
            assign side_in  = in_side;
            assign rada_in  = rad_a;
            assign radb_in  = rad_b;
            assign rema_in  = '0;
            assign remb_in  = '0;
            assign roota_in = '0;
            assign rootb_in = '0;
        end else begin : g_body
            assign v_in     = v_reg[j-1];
            assign side_in  = side_reg[j-1];
            assign rada_in  = rada_reg[j-1];
            assign radb_in  = radb_reg[j-1];
            assign rema_in  = rema_reg[j-1];
            assign remb_in  = remb_reg[j-1];
            assign roota_in = roota_reg[j-1];
            assign rootb_in = rootb_reg[j-1];
        end

        always_comb begin
            a_next = root_step(rema_in, roota_in, rada_in[2*(RW-1-j) +: 2]);
            b_next = root_step(remb_in, rootb_in, radb_in[2*(RW-1-j) +: 2]);
        end

        // Advance the valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        // Advance the digit state
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j]  <= side_in;
                rada_reg[j]  <= rada_in;
                radb_reg[j]  <= radb_in;
                rema_reg[j]  <= a_next[REM_W+RW-1:RW];
                remb_reg[j]  <= b_next[REM_W+RW-1:RW];
                roota_reg[j] <= a_next[RW-1:0];
                rootb_reg[j] <= b_next[RW-1:0];
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root_a    = roota_reg[RW-1];
    assign root_b    = rootb_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

/* rtl/wecost_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module wecost_div #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 42,
    parameter int QB    = 23,
    parameter int SW    = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [QB-1:0]     quot,
    output logic [SW-1:0]     out_side
);
    localparam int REM_W = DEN_W + QB;

    logic              v_reg    [0:QB-1];
    logic [SW-1:0]     side_reg [0:QB-1];
    logic [REM_W-1:0]  rem_reg  [0:QB-1];
    logic [DEN_W-1:0]  den_reg  [0:QB-1];
    logic [QB-1:0]     quot_reg [0:QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        logic              v_in;
        logic [SW-1:0]     side_in;
        logic [REM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QB-1:0]     quot_in;
        logic [REM_W-1:0]  dsh;
        logic [REM_W-1:0]  rem_next;
        logic [QB-1:0]     quot_next;

        if (j == 0) begin : g_head
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rem_in  = REM_W'(num);
            assign den_in  = den;
            assign quot_in = '0;
        end else begin : g_body
            assign v_in    = v_reg[j-1];
            assign side_in = side_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign quot_in = quot_reg[j-1];
        end

        // Try the divisor at this bit weight, subtract when it fits
        always_comb begin
            dsh       = REM_W'(den_in) << (QB - 1 - j);
            rem_next  = rem_in;
            quot_next = quot_in;
            if (rem_in >= dsh) begin
                rem_next            = rem_in - dsh;
                quot_next[QB-1-j]   = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= side_in;
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_in;
                quot_reg[j] <= quot_next;
            end
        end
    end

    assign out_valid = v_reg[QB-1];
    assign quot      = quot_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

/* rtl/walking_energy_edge_cost.sv */
// Top level: walking energy cost of one graph edge, fully pipelined.
//
// One edge beat is taken every clock while the result side keeps up; the whole
// pipeline holds when a finished result is not taken. Its stages include the
// two square roots (one root bit per stage), the gradient divider (23 stages),
// the five Horner steps (two stages each) and the split final multiply. The cost
// is C(g) times edge length in unsigned Q32.16, saturating; status reports a
// vertical edge or a non-positive polynomial, in which case the cost is zero.
module walking_energy_edge_cost #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COORD_WIDTH     = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_parent_x,
    input  logic signed [COORD_WIDTH-1:0]        s_parent_y,
    input  logic signed [COORD_WIDTH-1:0]        s_parent_z,
    input  logic signed [COORD_WIDTH-1:0]        s_child_x,
    input  logic signed [COORD_WIDTH-1:0]        s_child_y,
    input  logic signed [COORD_WIDTH-1:0]        s_child_z,
    input  logic [wecost_pkg::ID_W-1:0]          s_child_id,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [wecost_pkg::ID_W-1:0]          m_child_id_out,
    output logic [wecost_pkg::COST_W-1:0]        m_cost,
    output wecost_pkg::status_t                  m_status
);
    import wecost_pkg::*;

    localparam int DW         = COORD_WIDTH + 1;
    localparam int SQ_W       = 2 * DW;
    localparam int RUN2_W     = 2 * COORD_WIDTH + 3;
    localparam int LEN2_W     = RUN2_W + 1;
    localparam int SQW        = (LEN2_W + 2 * SQRT_EXTRA + 1) / 2;
    localparam int RAD_W      = 2 * SQW;
    localparam int NUM_W      = DW + GRAD_FRAC + SQRT_EXTRA;
    localparam int RSIDE_W    = ID_W + DW + 2;
    localparam int DSIDE_W    = ID_W + SQW + 3;
    localparam int PROD_W     = MAG_W + GRAD_W;
    localparam int PL_W       = LO_W + GRAD_W;
    localparam int PH_W       = HI_W + GRAD_W;
    localparam int PP_W       = 2 * LO_W;
    localparam int S_W        = 3 * LO_W;
    localparam int TOT_W      = 2 * ACC_W;
    localparam int COST_SHIFT = COORD_FRAC_BITS + SQRT_EXTRA;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [SQW-1:0]  len;
        logic            zero;
    } ctx_t;

    logic en;

    // Whole pipeline moves unless the result register is full and stalled
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: differences and magnitudes
    logic signed [DW-1:0] dx, dy, dz;
    logic                 v1_reg;
    logic [DW-1:0]        ax1_reg, ay1_reg, az1_reg;
    logic                 neg1_reg;
    logic [ID_W-1:0]      id1_reg;

    assign dx = DW'(s_child_x) - DW'(s_parent_x);
    assign dy = DW'(s_child_y) - DW'(s_parent_y);
    assign dz = DW'(s_child_z) - DW'(s_parent_z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            ay1_reg  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            az1_reg  <= dz[DW-1] ? DW'(-dz) : DW'(dz);
            neg1_reg <= dz[DW-1];
            id1_reg  <= s_child_id;
        end
    end

    // ---------------- stage 2: squares
    logic             v2_reg;
    logic [SQ_W-1:0]  sqx2_reg, sqy2_reg, sqz2_reg;
    logic [DW-1:0]    az2_reg;
    logic             neg2_reg;
    logic [ID_W-1:0]  id2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx2_reg <= SQ_W'(ax1_reg) * SQ_W'(ax1_reg);
            sqy2_reg <= SQ_W'(ay1_reg) * SQ_W'(ay1_reg);
            sqz2_reg <= SQ_W'(az1_reg) * SQ_W'(az1_reg);
            az2_reg  <= az1_reg;
            neg2_reg <= neg1_reg;
            id2_reg  <= id1_reg;
        end
    end

    // ---------------- stage 3: sums of squares
    logic [RUN2_W-1:0] run2_sum;
    logic [LEN2_W-1:0] len2_sum;
    logic              v3_reg;
    logic [RUN2_W-1:0] run2_3_reg;
    logic [LEN2_W-1:0] len2_3_reg;
    logic              zero3_reg;
    logic [DW-1:0]     az3_reg;
    logic              neg3_reg;
    logic [ID_W-1:0]   id3_reg;

    assign run2_sum = RUN2_W'(sqx2_reg) + RUN2_W'(sqy2_reg);
    assign len2_sum = LEN2_W'(run2_sum) + LEN2_W'(sqz2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            run2_3_reg <= run2_sum;
            len2_3_reg <= len2_sum;
            zero3_reg  <= (run2_sum == '0);
            az3_reg    <= az2_reg;
            neg3_reg   <= neg2_reg;
            id3_reg    <= id2_reg;
        end
    end

    // ---------------- square roots of run and length
    logic               rt_valid;
    logic [SQW-1:0]     rt_run, rt_len;
    logic [RSIDE_W-1:0] rt_side;
    logic [ID_W-1:0]    rt_id;
    logic [DW-1:0]      rt_az;
    logic               rt_neg, rt_zero;

    wecost_root2 #(
        .RW (SQW),
        .SW (RSIDE_W)
    ) u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .rad_a     (RAD_W'({run2_3_reg, {(2 * SQRT_EXTRA){1'b0}}})),
        .rad_b     (RAD_W'({len2_3_reg, {(2 * SQRT_EXTRA){1'b0}}})),
        .in_side   ({id3_reg, az3_reg, neg3_reg, zero3_reg}),
        .out_valid (rt_valid),
        .root_a    (rt_run),
        .root_b    (rt_len),
        .out_side  (rt_side)
    );

    assign {rt_id, rt_az, rt_neg, rt_zero} = rt_side;

    // ---------------- stage 4: steep-gradient test
    logic             v4_reg;
    logic             clamp4_reg;
    logic [DW-1:0]    az4_reg;
    logic [SQW-1:0]   run4_reg, len4_reg;
    logic             neg4_reg, zero4_reg;
    logic [ID_W-1:0]  id4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            clamp4_reg <= (SQW'({rt_az, 1'b0}) >= rt_run);
            az4_reg    <= rt_az;
            run4_reg   <= rt_run;
            len4_reg   <= rt_len;
            neg4_reg   <= rt_neg;
            zero4_reg  <= rt_zero;
            id4_reg    <= rt_id;
        end
    end

    // ---------------- gradient divider
    logic               dv_valid;
    logic [GRAD_QBITS-1:0] dv_quot;
    logic [DSIDE_W-1:0] dv_side;
    logic [ID_W-1:0]    dv_id;
    logic [SQW-1:0]     dv_len;
    logic               dv_neg, dv_zero, dv_clamp;

    wecost_div #(
        .NUM_W (NUM_W),
        .DEN_W (SQW),
        .QB    (GRAD_QBITS),
        .SW    (DSIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .num       ({az4_reg, {(GRAD_FRAC + SQRT_EXTRA){1'b0}}}),
        .den       (run4_reg),
        .in_side   ({id4_reg, len4_reg, neg4_reg, zero4_reg, clamp4_reg}),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    assign {dv_id, dv_len, dv_neg, dv_zero, dv_clamp} = dv_side;

    // ---------------- stage 5: signed gradient
    logic              v5_reg;
    logic [GRAD_W-1:0] gm5_reg;
    logic              gneg5_reg;
    ctx_t              ctx5_reg;
    logic [GRAD_W-1:0] gm_sel;

    assign gm_sel = dv_clamp ? GRAD_LIMIT : {1'b0, dv_quot};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gm5_reg   <= gm_sel;
            gneg5_reg <= dv_neg && (gm_sel != '0);
            ctx5_reg  <= '{id: dv_id, len: dv_len, zero: dv_zero};
        end
    end

    // ---------------- Horner steps, two stages each
    logic                     hv_a_reg    [0:4];
    ctx_t                     hctx_a_reg  [0:4];
    logic [GRAD_W-1:0]        hgm_a_reg   [0:4];
    logic                     hgneg_a_reg [0:4];
    logic                     hnegp_reg   [0:4];
    logic [PL_W-1:0]          hpl_reg     [0:4];
    logic [PH_W-1:0]          hph_reg     [0:4];
    logic                     hv_b_reg    [0:4];
    ctx_t                     hctx_b_reg  [0:4];
    logic [GRAD_W-1:0]        hgm_b_reg   [0:4];
    logic                     hgneg_b_reg [0:4];
    logic signed [ACC_W-1:0]  hacc_reg    [0:4];

    for (genvar k = 0; k < 5; k++) begin : g_horner
        logic                     v_in;
        ctx_t                     ctx_in;
        logic [GRAD_W-1:0]        gm_in;
        logic                     gneg_in;
        logic signed [ACC_W-1:0]  acc_in;
        logic [MAG_W-1:0]         mag_in;
        logic [PROD_W-1:0]        prod;
        logic [MAG_W-1:0]         pmag;
        logic signed [ACC_W-1:0]  sval;

        if (k == 0) begin : g_first
            assign v_in    = v5_reg;
            assign ctx_in  = ctx5_reg;
            assign gm_in   = gm5_reg;
            assign gneg_in = gneg5_reg;
            assign acc_in  = POLY_C5;
        end else begin : g_next
            assign v_in    = hv_b_reg[k-1];
            assign ctx_in  = hctx_b_reg[k-1];
            assign gm_in   = hgm_b_reg[k-1];
            assign gneg_in = hgneg_b_reg[k-1];
            assign acc_in  = hacc_reg[k-1];
        end

        assign mag_in = acc_in[ACC_W-1] ? MAG_W'(-acc_in) : MAG_W'(acc_in);

        // Join partial products, drop 16 fraction bits, restore sign, add term
        always_comb begin
            prod = (PROD_W'(hph_reg[k]) << LO_W) + PROD_W'(hpl_reg[k]);
            pmag = MAG_W'(prod >> GRAD_FRAC);
            sval = hnegp_reg[k] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hv_a_reg[k] <= 1'b0;
                hv_b_reg[k] <= 1'b0;
            end else if (en) begin
                hv_a_reg[k] <= v_in;
                hv_b_reg[k] <= hv_a_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                hctx_a_reg[k]  <= ctx_in;
                hgm_a_reg[k]   <= gm_in;
                hgneg_a_reg[k] <= gneg_in;
                hnegp_reg[k]   <= acc_in[ACC_W-1] ^ gneg_in;
                hpl_reg[k]     <= PL_W'(mag_in[LO_W-1:0]) * PL_W'(gm_in);
                hph_reg[k]     <= PH_W'(mag_in[MAG_W-1:LO_W]) * PH_W'(gm_in);
                hctx_b_reg[k]  <= hctx_a_reg[k];
                hgm_b_reg[k]   <= hgm_a_reg[k];
                hgneg_b_reg[k] <= hgneg_a_reg[k];
                hacc_reg[k]    <= sval + horner_add(3'(k));
            end
        end
    end

    // ---------------- cost multiply, split into 32-bit partial products
    logic signed [ACC_W-1:0] pacc;
    ctx_t                    pctx;
    logic [ACC_W-1:0]        plen;

    assign pacc = hacc_reg[4];
    assign pctx = hctx_b_reg[4];
    assign plen = ACC_W'(pctx.len);

    logic              p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [PP_W-1:0]   p1_pp0_reg, p1_pp1_reg;
    logic [MAG_W-1:0]  p1_acc_reg;
    logic [LO_W-1:0]   p1_lhi_reg;
    logic              p1_nonpos_reg, p2_nonpos_reg, p3_nonpos_reg, p4_nonpos_reg;
    logic              p1_zero_reg, p2_zero_reg, p3_zero_reg, p4_zero_reg;
    logic [ID_W-1:0]   p1_id_reg, p2_id_reg, p3_id_reg, p4_id_reg;
    logic [PP_W-1:0]   p2_pp2_reg, p2_pp3_reg;
    logic [S_W-1:0]    p2_s1_reg, p3_s1_reg, p3_s2_reg;
    logic [TOT_W-1:0]  p4_tot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end else if (en) begin
            p1_v_reg <= hv_b_reg[4];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // low half of length
            p1_pp0_reg    <= PP_W'(pacc[LO_W-1:0]) * PP_W'(plen[LO_W-1:0]);
            p1_pp1_reg    <= PP_W'(pacc[MAG_W-1:LO_W]) * PP_W'(plen[LO_W-1:0]);
            p1_acc_reg    <= pacc[MAG_W-1:0];
            p1_lhi_reg    <= plen[ACC_W-1:LO_W];
            p1_nonpos_reg <= pacc[ACC_W-1] || (pacc == '0);
            p1_zero_reg   <= pctx.zero;
            p1_id_reg     <= pctx.id;
            // high half of length, fold first pair
            p2_pp2_reg    <= PP_W'(p1_acc_reg[LO_W-1:0]) * PP_W'(p1_lhi_reg);
            p2_pp3_reg    <= PP_W'(p1_acc_reg[MAG_W-1:LO_W]) * PP_W'(p1_lhi_reg);
            p2_s1_reg     <= S_W'(p1_pp0_reg) + (S_W'(p1_pp1_reg) << LO_W);
            p2_nonpos_reg <= p1_nonpos_reg;
            p2_zero_reg   <= p1_zero_reg;
            p2_id_reg     <= p1_id_reg;
            // fold second pair
            p3_s1_reg     <= p2_s1_reg;
            p3_s2_reg     <= S_W'(p2_pp2_reg) + (S_W'(p2_pp3_reg) << LO_W);
            p3_nonpos_reg <= p2_nonpos_reg;
            p3_zero_reg   <= p2_zero_reg;
            p3_id_reg     <= p2_id_reg;
            // full product
            p4_tot_reg    <= TOT_W'(p3_s1_reg) + (TOT_W'(p3_s2_reg) << LO_W);
            p4_nonpos_reg <= p3_nonpos_reg;
            p4_zero_reg   <= p3_zero_reg;
            p4_id_reg     <= p3_id_reg;
        end
    end

    // ---------------- result register: scale, saturate, status
    logic [TOT_W-1:0]   tot_sh;
    logic [COST_W-1:0]  cost_sat;
    status_t            status_next;
    logic               m_valid_reg;
    logic [ID_W-1:0]    m_id_reg;
    logic [COST_W-1:0]  m_cost_reg;
    status_t            m_status_reg;

    always_comb begin
        tot_sh   = p4_tot_reg >> COST_SHIFT;
        cost_sat = (tot_sh[TOT_W-1:COST_W] != '0) ? {COST_W{1'b1}} : tot_sh[COST_W-1:0];
        if (p4_zero_reg) begin
            status_next = ST_ZERO_RUN;
        end else if (p4_nonpos_reg) begin
            status_next = ST_NONPOS;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_id_reg     <= p4_id_reg;
            m_status_reg <= status_next;
            m_cost_reg   <= (status_next == ST_OK) ? cost_sat : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_child_id_out = m_id_reg;
    assign m_cost         = m_cost_reg;
    assign m_status       = m_status_reg;

endmodule

/* rtl/wecost_checker.sv */
// Port-level checks on the walking energy edge cost block, bound to the top level.
module wecost_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [wecost_pkg::ID_W-1:0]   m_child_id_out,
    input logic [wecost_pkg::COST_W-1:0] m_cost,
    input wecost_pkg::status_t           m_status
);
    import wecost_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cost) && $stable(m_status)
            && $stable(m_child_id_out))
        else $error("stalled result beat changed");

    // A stalled result blocks the input side
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // Flagged edges carry no cost
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ZERO_RUN || m_status == ST_NONPOS) |-> m_cost == '0)
        else $error("flagged edge with non-zero cost");

endmodule

bind walking_energy_edge_cost wecost_checker u_wecost_checker (.*);

/* dv/walking_energy_edge_cost_tb.sv */
// Self-checking testbench for the walking energy edge cost block.
`timescale 1ns / 100ps

module walking_energy_edge_cost_tb;
    import wecost_pkg::*;

    localparam int FRAC = 16;
    localparam int CW   = 32;
    localparam int LAT  = CW + 53;
    localparam int N_RANDOM   = 1630;
    localparam int QUIET_TAIL = 200;
    localparam int HOLD_LONG  = 300;

    localparam logic [47:0] COST_SAT = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [63:0] HC5 = 64'sd18382848;
    localparam logic signed [63:0] HC4 = 64'sd3846963;
    localparam logic signed [63:0] HC3 = 64'sd5033165;
    localparam logic signed [63:0] HC2 = 64'sd3401318;
    localparam logic signed [63:0] HC1 = 64'sd1284506;
    localparam logic signed [63:0] HC0 = 64'sd163840;
    localparam logic signed [63:0] GRAD_CLAMP = 64'sd8388608;

    typedef struct packed {
        logic [31:0] child_id;
        logic [47:0] cost;
        status_t     status;
    } edge_cost_t;

    // Q16 product with magnitude truncation
    function automatic logic signed [63:0] q16_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic         neg;
        logic [127:0] p;
        logic [63:0]  m;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        m = {1'b0, p[78:16]};
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Floor square root of a 128-bit value
    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic edge_cost_t edge_cost(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [31:0] cx,
                                             logic [31:0] cy, logic [31:0] cz,
                                             logic [31:0] id);
        edge_cost_t r;
        logic signed [63:0] dx, dy, dz, g, acc;
        logic [63:0] ax, ay, az, run, len;
        logic [127:0] run2, len2, prod;
        dx = 64'($signed(cx)) - 64'($signed(px));
        dy = 64'($signed(cy)) - 64'($signed(py));
        dz = 64'($signed(cz)) - 64'($signed(pz));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        az = dz < 0 ? -dz : dz;
        run2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        len2 = run2 + 128'(az) * 128'(az);
        r.child_id = id;
        r.cost = '0;
        r.status = ST_OK;
        if (run2 == 0) begin
            r.status = ST_ZERO_RUN;
        end else begin
            run = isqrt128(run2 << 16);
            len = isqrt128(len2 << 16);
            if (128'(az) * 2 >= 128'(run)) g = GRAD_CLAMP;
            else g = $signed(64'((128'(az) << 24) / 128'(run)));
            if (dz < 0) g = -g;
            acc = q16_mul(HC5, g) - HC4;
            acc = q16_mul(acc, g) - HC3;
            acc = q16_mul(acc, g) + HC2;
            acc = q16_mul(acc, g) + HC1;
            acc = q16_mul(acc, g) + HC0;
            if (acc <= 0) begin
                r.status = ST_NONPOS;
            end else begin
                prod = (128'(acc) * 128'(len)) >> (FRAC + 8);
                r.cost = prod > 128'(COST_SAT) ? COST_SAT : prod[47:0];
            end
        end
        return r;
    endfunction

    class cost_scoreboard;
        edge_cost_t pending[$];
        int mismatches;

        function void note_edge(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [31:0] id);
            pending = {pending, edge_cost(px, py, pz, cx, cy, cz, id)};
        endfunction

        function void check_result(edge_cost_t got);
            edge_cost_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat id=%h", got.child_id);
                return;
            end
            want = pending.pop_front();
            if (got.child_id !== want.child_id || got.cost !== want.cost ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want id=%h cost=%h st=%0d, got id=%h cost=%h st=%0d",
                             want.child_id, want.cost, want.status,
                             got.child_id, got.cost, got.status);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_parent_x = '0, s_parent_y = '0, s_parent_z = '0;
    logic signed [31:0] s_child_x = '0, s_child_y = '0, s_child_z = '0;
    logic [31:0] s_child_id = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_child_id_out;
    logic [47:0] m_cost;
    status_t m_status;

    cost_scoreboard board = new();
    bit quiet = 1'b0;
    bit hold_requested = 1'b0;
    bit hold_done = 1'b0;

    walking_energy_edge_cost dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one edge beat and hold it until taken
    task automatic send_edge(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] id);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_parent_x <= px; s_parent_y <= py; s_parent_z <= pz;
        s_child_x <= cx; s_child_y <= cy; s_child_z <= cz;
        s_child_id <= id;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_edge(px, py, pz, cx, cy, cz, id);
        @(negedge aclk);
    endtask

    // Random coordinate: full range, or near a base so gradients stay sensible
    function automatic logic [31:0] near(logic [31:0] base, int span);
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return base;
            default: return base + 32'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    initial begin
        logic [31:0] bx, by, bz;
        int span;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Directed edges: extremes, vertical, steep and flat cases
        send_edge(0, 0, 0, 0, 0, 0, 32'h0);
        send_edge(0, 0, 0, 0, 0, 32'h0001_0000, 32'hFFFF_FFFF);
        send_edge(0, 0, 0, 32'h0001_0000, 0, 0, 32'h1);
        send_edge(0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h2);
        send_edge(0, 0, 0, 32'h0001_0000, 0, 32'hFFFF_0000, 32'h3);
        send_edge(0, 0, 0, 32'h0001_0000, 0, 32'h0000_4000, 32'h4);
        send_edge(0, 0, 0, 32'h0001_0000, 0, 32'hFFFF_C000, 32'h5);
        send_edge(0, 0, 0, 32'h0001_0000, 0, 32'hFFFF_E000, 32'h6);
        send_edge(0, 0, 0, 32'h0000_0001, 0, 32'h7FFF_FFFF, 32'h7);
        send_edge(0, 0, 0, 32'h0000_0001, 0, 32'h8000_0000, 32'h8);
        send_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h9);
        send_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hA);
        send_edge(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'hB);
        send_edge(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 32'hC);
        send_edge(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 0, 32'hD);
        send_edge(0, 0, 0, 32'h0000_0001, 0, 0, 32'hE);
        send_edge(0, 0, 0, 32'h0000_0100, 0, 32'h0000_7F00, 32'hF);
        send_edge(0, 0, 0, 32'h0000_0100, 0, 32'h0000_8000, 32'h10);
        send_edge(0, 0, 0, 32'h0000_0100, 0, 32'hFFFF_8000, 32'h11);
        send_edge(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h1234_5678,
                  32'h8765_4321, 32'h0, 32'h12);
        send_edge(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h13);
        send_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 32'h8000_0000);
        // Sender pause: let the pipeline drain completely
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        @(negedge aclk);
        // Receiver hold-off while edges keep coming
        hold_requested = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            bx = $urandom(); by = $urandom(); bz = $urandom();
            span = (1 << $urandom_range(0, 20));
            send_edge(bx, by, bz, near(bx, span), near(by, span),
                      near(bz, span), $urandom());
        end
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (LAT + 10) @(negedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("walking_energy_edge_cost_tb OK");
        else
            $display("walking_energy_edge_cost_tb NOT OK");
        $finish;
    end

    // Result side: random stalls, one long hold-off
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_requested && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_LONG) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check each result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_child_id_out, m_cost, m_status});
    end

    initial begin
        #5ms;
        $display("walking_energy_edge_cost_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/wecost_pkg.sv
rtl/wecost_root2.sv
rtl/wecost_div.sv
rtl/walking_energy_edge_cost.sv
rtl/wecost_checker.sv
dv/walking_energy_edge_cost_tb.sv
